[sv/lirs_pkg.sv]
// State type and sequencer state codes for the linear interpolation resampler.
package lirs_pkg;

    typedef logic [2:0] t_state;

    localparam t_state S_IDLE = 3'd0;
    localparam t_state S_MUL  = 3'd1;
    localparam t_state S_EMIT = 3'd2;
    localparam t_state S_TAIL = 3'd3;

endpackage

[sv/linear_interp_resampler_top.sv]
// Linear interpolation sample rate converter: one shared multiplier under a small sequencer.
// After acceptance a result is multiplied in S_MUL, then added, saturated and registered in S_EMIT;
// an end-clamp result is registered from S_TAIL, which a single-sample stream reaches from S_IDLE directly.
// Input stall is held while the sequencer is not in S_IDLE, so a new item is taken only once the
// sequencer has finished every result of the previous item.
// Synchronous active-low reset clears step to 1.0 and the held sample, flag and phase to zero.
module linear_interp_resampler_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [FRAC_BITS+4:0]          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_run_last,
    output logic                          o_stream_end
);
    import lirs_pkg::*;

    localparam int PW = FRAC_BITS + 5;               // phase and step width
    localparam int DW = SAMPLE_BITS + 1;             // difference width
    localparam int MW = DW + FRAC_BITS + 1;          // product width
    localparam int QW = MW - FRAC_BITS;              // truncated quotient width
    localparam int SW = SAMPLE_BITS + 3;             // sum width

    localparam logic [PW-1:0] ONE_Q    = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [PW-1:0] TWO_Q    = ONE_Q << 1;
    localparam logic [PW-1:0] STEP_MIN = ONE_Q >> 4;
    localparam logic [PW-1:0] STEP_MAX = ONE_Q << 4;
    localparam logic [PW-1:0] PHASE_LIM = ONE_Q + STEP_MAX;
    localparam logic signed [SW-1:0] SMAX = SW'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
    localparam logic signed [MW-1:0] RND  = MW'((1 << FRAC_BITS) - 1);

    t_state                   r_state, n_state;
    logic [PW-1:0]            r_step;
    logic [PW-1:0]            r_phase, n_phase;
    logic signed [SAMPLE_BITS-1:0] r_held, n_held;
    logic                     r_have_held, n_have_held;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                     r_last;
    logic signed [MW-1:0]     r_prod;
    logic                     r_ov, n_ov;
    logic signed [SAMPLE_BITS-1:0] r_out, n_out;
    logic                     r_rl, n_rl;
    logic                     r_se, n_se;

    logic                     in_acc;
    logic                     slot_free;
    logic [PW-1:0]            np;
    logic signed [DW-1:0]     diff;
    logic signed [MW-1:0]     prod;
    logic signed [MW-1:0]     prod_adj;
    logic signed [QW-1:0]     quot;
    logic signed [SW-1:0]     sum;
    logic signed [SAMPLE_BITS-1:0] sat;

    assign o_in_stall   = (r_state != S_IDLE);
    assign in_acc       = i_in_valid && (r_state == S_IDLE);
    assign slot_free    = !r_ov || !i_out_stall;
    assign o_out_valid  = r_ov;
    assign o_sample_out = r_out;
    assign o_run_last   = r_rl;
    assign o_stream_end = r_se;

    assign np   = r_phase + r_step;
    assign diff = DW'(r_x) - DW'(r_held);
    // the one multiplier: fraction times sample difference
    assign prod = MW'($signed({1'b0, r_phase[FRAC_BITS-1:0]})) * MW'(diff);

    // truncate toward zero, add to held sample, saturate
    assign prod_adj = r_prod + (r_prod[MW-1] ? RND : '0);
    assign quot     = QW'(prod_adj >>> FRAC_BITS);
    assign sum      = SW'(r_held) + SW'(quot);
    always_comb begin
        if (sum > SMAX) begin
            sat = SAMPLE_BITS'(SMAX);
        end else if (sum < SMIN) begin
            sat = SAMPLE_BITS'(SMIN);
        end else begin
            sat = SAMPLE_BITS'(sum);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_held      = r_held;
        n_have_held = r_have_held;
        n_ov        = r_ov && i_out_stall;
        n_out       = r_out;
        n_rl        = r_rl;
        n_se        = r_se;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_have_held) begin
                        n_state = S_MUL;
                    end else begin
                        n_phase = '0;
                        n_state = S_TAIL;
                    end
                end
            end
            S_MUL: begin
                if (r_phase < ONE_Q) begin
                    n_state = S_EMIT;
                end else begin
                    n_phase = r_phase - ONE_Q;
                    n_state = S_TAIL;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_out   = sat;
                    n_rl    = !(np < ONE_Q) && !(r_last && (np < TWO_Q));
                    n_se    = !(np < ONE_Q) && !(r_last && (np < TWO_Q)) && r_last;
                    n_phase = np;
                    n_state = S_MUL;
                end
            end
            S_TAIL: begin
                if (!r_last) begin
                    n_held      = r_x;
                    n_have_held = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_phase < ONE_Q) begin
                    // end clamp: repeat the last sample
                    if (slot_free) begin
                        n_ov    = 1'b1;
                        n_out   = r_x;
                        n_rl    = !(np < ONE_Q);
                        n_se    = !(np < ONE_Q);
                        n_phase = np;
                    end
                end else begin
                    n_held      = '0;
                    n_have_held = 1'b0;
                    n_phase     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ONE_Q;
            r_phase     <= '0;
            r_held      <= '0;
            r_have_held <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_have_held <= n_have_held;
            r_ov        <= n_ov;
            if (i_cfg_we) begin
                if (i_cfg_data < STEP_MIN) begin
                    r_step <= STEP_MIN;
                end else if (i_cfg_data > STEP_MAX) begin
                    r_step <= STEP_MAX;
                end else begin
                    r_step <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x    <= i_sample_in;
            r_last <= i_is_last;
        end
        if (r_state == S_MUL) begin
            r_prod <= prod;
        end
        r_out <= n_out;
        r_rl  <= n_rl;
        r_se  <= n_se;
    end

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < PHASE_LIM)
        else $error("phase accumulator out of range");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_have_held) |-> (r_phase == '0))
        else $error("phase not cleared between streams");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_EMIT || r_state == S_TAIL))
        else $error("result produced outside emit states");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_se) |-> r_rl)
        else $error("stream end without run last");

endmodule
